// File: rtl/space_vector_pwm_q15_top_defines.svh
// Assertion macros for the space vector PWM block
`ifndef SPACE_VECTOR_PWM_Q15_TOP_DEFINES_SVH
`define SPACE_VECTOR_PWM_Q15_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define SVPWM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SVPWM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SVPWM_ASSERT_NOW(name, ante, cons, msg)

`define SVPWM_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: rtl/svpwm_pkg.sv
package svpwm_pkg;

    localparam int IN_W      = 24;
    localparam int CFG_W     = 15;
    localparam int DUTY_W    = 16;
    localparam int VAL_W     = 26;
    localparam int SUM_W     = 27;
    localparam int MAG_W     = 25;
    localparam int DIV_W     = 26;
    localparam int T_W       = 28;
    localparam int PERIOD    = 32768;
    localparam int PERIOD_SH = 15;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 4;

    localparam logic signed [17:0] ROOT3_Q15 = 18'sd56756;
    localparam logic [CFG_W-1:0]   IBV_RESET = 15'd1365;
    localparam logic [DUTY_W-1:0]  DUTY_HALF = 16'd16384;
    localparam logic [DUTY_W-1:0]  DUTY_FULL = 16'd32768;

    typedef enum logic [2:0] {
        SEC_NONE_LO = 3'd0,
        SEC_1       = 3'd1,
        SEC_2       = 3'd2,
        SEC_3       = 3'd3,
        SEC_4       = 3'd4,
        SEC_5       = 3'd5,
        SEC_6       = 3'd6,
        SEC_NONE_HI = 3'd7
    } sector_t;

    typedef struct packed {
        sector_t                   sector;
        logic                      over;
        logic signed [VAL_W-1:0]   m;
        logic signed [VAL_W-1:0]   s;
        logic signed [SUM_W-1:0]   sum;
    } vec_t;

    typedef struct packed {
        sector_t                   sector;
        logic                      over;
        logic signed [VAL_W-1:0]   m;
        logic signed [VAL_W-1:0]   s;
        logic [MAG_W-1:0]          qm;
        logic [MAG_W-1:0]          qs;
    } quot_t;

endpackage

// File: rtl/svpwm_vec.sv
module svpwm_vec
    import svpwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CFG_W-1:0]        inv,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  alpha,
    input  logic signed [IN_W-1:0]  beta,
    output logic                    out_valid,
    input  logic                    out_ready,
    output vec_t                    out_data
);

    localparam int NS  = 5;
    localparam int PW  = 42;
    localparam int TW3 = IN_W + 3;
    localparam int MW  = VAL_W + CFG_W + 1;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] stage_in;
    logic [NS-1:0] en;

    // stage 1
    logic signed [PW-1:0]    pa;
    logic signed [PW-1:0]    pb;
    logic signed [PW-1:0]    npa;
    logic signed [TW3-1:0]   t3;
    logic signed [TW3-1:0]   nt3;
    logic signed [VAL_W-1:0] sa1_reg;
    logic signed [VAL_W-1:0] nsa1_reg;
    logic signed [VAL_W-1:0] x1_reg;
    logic signed [VAL_W-1:0] bh1_reg;
    logic signed [VAL_W-1:0] ah1_reg;
    logic signed [VAL_W-1:0] nah1_reg;
    logic signed [IN_W-1:0]  beta1_reg;

    // stage 2
    logic signed [SUM_W-1:0] d1;
    logic signed [SUM_W-1:0] d2;
    logic                    bpos;
    sector_t                 sec2_reg;
    logic signed [VAL_W-1:0] x2_reg;
    logic signed [VAL_W-1:0] y2_reg;
    logic signed [VAL_W-1:0] z2_reg;

    // stage 3
    logic signed [VAL_W-1:0] mr;
    logic signed [VAL_W-1:0] sr;
    logic                    mneg;
    logic                    sneg;
    sector_t                 sec3_reg;
    logic signed [VAL_W-1:0] mr3_reg;
    logic signed [VAL_W-1:0] sr3_reg;
    logic                    mneg3_reg;
    logic                    sneg3_reg;

    // stage 4
    logic signed [MW-1:0]    prod_m;
    logic signed [MW-1:0]    prod_s;
    sector_t                 sec4_reg;
    logic signed [VAL_W-1:0] mp4_reg;
    logic signed [VAL_W-1:0] sp4_reg;
    logic                    mneg4_reg;
    logic                    sneg4_reg;

    // stage 5
    logic signed [VAL_W-1:0] m5;
    logic signed [VAL_W-1:0] s5;
    logic signed [SUM_W-1:0] sum5;
    logic                    active5;
    vec_t                    out_reg;

    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = out_ready || !(&v_reg[NS-1:k]);
    end

    assign stage_in  = {v_reg[NS-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= stage_in[k];
                end
            end
        end
    end

    assign pa  = PW'(alpha) * PW'(ROOT3_Q15);
    assign pb  = PW'(beta) * PW'(ROOT3_Q15);
    assign npa = -pa;
    assign t3  = TW3'(alpha) + (TW3'(alpha) <<< 1);
    assign nt3 = -t3;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sa1_reg   <= VAL_W'(pa >>> PERIOD_SH);
            nsa1_reg  <= VAL_W'(npa >>> PERIOD_SH);
            x1_reg    <= VAL_W'(pb >>> PERIOD_SH);
            bh1_reg   <= VAL_W'(pb >>> (PERIOD_SH + 1));
            ah1_reg   <= VAL_W'(t3 >>> 1);
            nah1_reg  <= VAL_W'(nt3 >>> 1);
            beta1_reg <= beta;
        end
    end

    assign d1   = SUM_W'(sa1_reg) - SUM_W'(beta1_reg);
    assign d2   = SUM_W'(nsa1_reg) - SUM_W'(beta1_reg);
    assign bpos = !beta1_reg[IN_W-1] && (beta1_reg != '0);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sec2_reg <= sector_t'({(d2 > SUM_W'(1)), (d1 > SUM_W'(1)), bpos});
            x2_reg   <= x1_reg;
            y2_reg   <= ah1_reg + bh1_reg;
            z2_reg   <= nah1_reg + bh1_reg;
        end
    end

    always_comb
    begin
        mr   = x2_reg;
        sr   = y2_reg;
        mneg = 1'b0;
        sneg = 1'b0;
        unique case (sec2_reg)
            SEC_1:
            begin
                mr = z2_reg;
                sr = y2_reg;
            end
            SEC_2:
            begin
                mr   = y2_reg;
                sr   = x2_reg;
                sneg = 1'b1;
            end
            SEC_3:
            begin
                mr   = z2_reg;
                mneg = 1'b1;
                sr   = x2_reg;
            end
            SEC_4:
            begin
                mr   = x2_reg;
                mneg = 1'b1;
                sr   = z2_reg;
            end
            SEC_5:
            begin
                mr   = x2_reg;
                sr   = y2_reg;
                sneg = 1'b1;
            end
            SEC_6:
            begin
                mr   = y2_reg;
                mneg = 1'b1;
                sr   = z2_reg;
                sneg = 1'b1;
            end
            SEC_NONE_LO, SEC_NONE_HI:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sec3_reg  <= sec2_reg;
            mr3_reg   <= mr;
            sr3_reg   <= sr;
            mneg3_reg <= mneg;
            sneg3_reg <= sneg;
        end
    end

    assign prod_m = MW'(mr3_reg) * MW'($signed({1'b0, inv}));
    assign prod_s = MW'(sr3_reg) * MW'($signed({1'b0, inv}));

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sec4_reg  <= sec3_reg;
            mp4_reg   <= VAL_W'(prod_m >>> PERIOD_SH);
            sp4_reg   <= VAL_W'(prod_s >>> PERIOD_SH);
            mneg4_reg <= mneg3_reg;
            sneg4_reg <= sneg3_reg;
        end
    end

    assign m5      = mneg4_reg ? -mp4_reg : mp4_reg;
    assign s5      = sneg4_reg ? -sp4_reg : sp4_reg;
    assign sum5    = SUM_W'(m5) + SUM_W'(s5);
    assign active5 = (sec4_reg != SEC_NONE_LO) && (sec4_reg != SEC_NONE_HI);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            out_reg.sector <= sec4_reg;
            out_reg.over   <= active5 && (sum5 > SUM_W'(PERIOD));
            out_reg.m      <= m5;
            out_reg.s      <= s5;
            out_reg.sum    <= sum5;
        end
    end

endmodule

// File: rtl/svpwm_div.sv
module svpwm_div
    import svpwm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  vec_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output quot_t out_data
);

    localparam int NS = MAG_W + 1;

    typedef struct packed {
        sector_t                 sector;
        logic                    over;
        logic signed [VAL_W-1:0] m;
        logic signed [VAL_W-1:0] s;
    } side_t;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] stage_in;
    logic [NS-1:0] en;

    logic [DIV_W-1:0] rm_reg [NS];
    logic [DIV_W-1:0] rs_reg [NS];
    logic [MAG_W-1:0] wm_reg [NS];
    logic [MAG_W-1:0] ws_reg [NS];
    logic [DIV_W-1:0] dv_reg [NS];
    side_t            side_reg [NS];

    logic signed [VAL_W-1:0] neg_m;
    logic signed [VAL_W-1:0] neg_s;
    logic [MAG_W-1:0]        mag_m;
    logic [MAG_W-1:0]        mag_s;

    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = out_ready || !(&v_reg[NS-1:k]);
    end

    assign stage_in  = {v_reg[NS-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= stage_in[k];
                end
            end
        end
    end

    assign neg_m = -in_data.m;
    assign neg_s = -in_data.s;
    assign mag_m = in_data.m[VAL_W-1] ? neg_m[MAG_W-1:0] : in_data.m[MAG_W-1:0];
    assign mag_s = in_data.s[VAL_W-1] ? neg_s[MAG_W-1:0] : in_data.s[MAG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rm_reg[0]          <= DIV_W'(mag_m >> (MAG_W - PERIOD_SH));
            rs_reg[0]          <= DIV_W'(mag_s >> (MAG_W - PERIOD_SH));
            wm_reg[0]          <= mag_m << PERIOD_SH;
            ws_reg[0]          <= mag_s << PERIOD_SH;
            dv_reg[0]          <= in_data.sum[DIV_W-1:0];
            side_reg[0].sector <= in_data.sector;
            side_reg[0].over   <= in_data.over;
            side_reg[0].m      <= in_data.m;
            side_reg[0].s      <= in_data.s;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_step
        logic [DIV_W:0]   sh_m;
        logic [DIV_W:0]   sh_s;
        logic [DIV_W+1:0] tr_m;
        logic [DIV_W+1:0] tr_s;

        assign sh_m = {rm_reg[k-1], wm_reg[k-1][MAG_W-1]};
        assign sh_s = {rs_reg[k-1], ws_reg[k-1][MAG_W-1]};
        assign tr_m = {1'b0, sh_m} - {2'b0, dv_reg[k-1]};
        assign tr_s = {1'b0, sh_s} - {2'b0, dv_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rm_reg[k]   <= tr_m[DIV_W+1] ? sh_m[DIV_W-1:0] : tr_m[DIV_W-1:0];
                rs_reg[k]   <= tr_s[DIV_W+1] ? sh_s[DIV_W-1:0] : tr_s[DIV_W-1:0];
                wm_reg[k]   <= {wm_reg[k-1][MAG_W-2:0], !tr_m[DIV_W+1]};
                ws_reg[k]   <= {ws_reg[k-1][MAG_W-2:0], !tr_s[DIV_W+1]};
                dv_reg[k]   <= dv_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_data.sector = side_reg[NS-1].sector;
    assign out_data.over   = side_reg[NS-1].over;
    assign out_data.m      = side_reg[NS-1].m;
    assign out_data.s      = side_reg[NS-1].s;
    assign out_data.qm     = wm_reg[NS-1];
    assign out_data.qs     = ws_reg[NS-1];

endmodule

// File: rtl/svpwm_duty.sv
module svpwm_duty
    import svpwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  quot_t             in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DUTY_W-1:0] duty_a,
    output logic [DUTY_W-1:0] duty_b,
    output logic [DUTY_W-1:0] duty_c,
    output sector_t           sector_code,
    output logic              overmodulated
);

    localparam int NS = 4;
    localparam int DW = T_W + 2;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] stage_in;
    logic [NS-1:0] en;

    // stage 1
    logic signed [VAL_W-1:0] qm_s;
    logic signed [VAL_W-1:0] qs_s;
    sector_t                 sec1_reg;
    logic                    over1_reg;
    logic signed [VAL_W-1:0] mf1_reg;
    logic signed [VAL_W-1:0] sf1_reg;

    // stage 2
    logic signed [T_W-1:0]   diff2;
    sector_t                 sec2_reg;
    logic                    over2_reg;
    logic signed [T_W-1:0]   ta2_reg;
    logic signed [T_W-1:0]   hm2_reg;
    logic signed [T_W-1:0]   hs2_reg;

    // stage 3
    logic signed [T_W-1:0]   tb3;
    sector_t                 sec3_reg;
    logic                    over3_reg;
    logic signed [T_W-1:0]   ta3_reg;
    logic signed [T_W-1:0]   tb3_reg;
    logic signed [T_W-1:0]   tc3_reg;

    // stage 4
    logic signed [T_W-1:0]   c1;
    logic signed [T_W-1:0]   c2;
    logic signed [T_W-1:0]   c3;
    logic                    active4;
    logic [DUTY_W-1:0]       da_reg;
    logic [DUTY_W-1:0]       db_reg;
    logic [DUTY_W-1:0]       dc_reg;
    sector_t                 sec4_reg;
    logic                    over4_reg;

    function automatic logic [DUTY_W-1:0] duty_of(input logic signed [T_W-1:0] c);
        logic signed [DW-1:0] d;
        logic [DUTY_W-1:0]    r;
        d = DW'(PERIOD) - (DW'(c) <<< 1);
        priority if (d < DW'(0))
            r = '0;
        else if (d > DW'(PERIOD))
            r = DUTY_FULL;
        else
            r = d[DUTY_W-1:0];
        return r;
    endfunction

    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = out_ready || !(&v_reg[NS-1:k]);
    end

    assign stage_in  = {v_reg[NS-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= stage_in[k];
                end
            end
        end
    end

    assign qm_s = in_data.m[VAL_W-1] ? -VAL_W'({1'b0, in_data.qm}) : VAL_W'({1'b0, in_data.qm});
    assign qs_s = in_data.s[VAL_W-1] ? -VAL_W'({1'b0, in_data.qs}) : VAL_W'({1'b0, in_data.qs});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sec1_reg  <= in_data.sector;
            over1_reg <= in_data.over;
            mf1_reg   <= in_data.over ? qm_s : in_data.m;
            sf1_reg   <= in_data.over ? qs_s : in_data.s;
        end
    end

    assign diff2 = T_W'(PERIOD) - T_W'(mf1_reg) - T_W'(sf1_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sec2_reg  <= sec1_reg;
            over2_reg <= over1_reg;
            ta2_reg   <= diff2 >>> 2;
            hm2_reg   <= T_W'(mf1_reg) >>> 1;
            hs2_reg   <= T_W'(sf1_reg) >>> 1;
        end
    end

    assign tb3 = ta2_reg + hm2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sec3_reg  <= sec2_reg;
            over3_reg <= over2_reg;
            ta3_reg   <= ta2_reg;
            tb3_reg   <= tb3;
            tc3_reg   <= tb3 + hs2_reg;
        end
    end

    always_comb
    begin
        c1      = ta3_reg;
        c2      = tb3_reg;
        c3      = tc3_reg;
        active4 = 1'b1;
        unique case (sec3_reg)
            SEC_1:
            begin
                c1 = tb3_reg;
                c2 = ta3_reg;
                c3 = tc3_reg;
            end
            SEC_2:
            begin
                c1 = ta3_reg;
                c2 = tc3_reg;
                c3 = tb3_reg;
            end
            SEC_3:
            begin
                c1 = ta3_reg;
                c2 = tb3_reg;
                c3 = tc3_reg;
            end
            SEC_4:
            begin
                c1 = tc3_reg;
                c2 = tb3_reg;
                c3 = ta3_reg;
            end
            SEC_5:
            begin
                c1 = tc3_reg;
                c2 = ta3_reg;
                c3 = tb3_reg;
            end
            SEC_6:
            begin
                c1 = tb3_reg;
                c2 = tc3_reg;
                c3 = ta3_reg;
            end
            SEC_NONE_LO, SEC_NONE_HI:
            begin
                active4 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            da_reg    <= active4 ? duty_of(c1) : DUTY_HALF;
            db_reg    <= active4 ? duty_of(c2) : DUTY_HALF;
            dc_reg    <= active4 ? duty_of(c3) : DUTY_HALF;
            sec4_reg  <= sec3_reg;
            over4_reg <= active4 && over3_reg;
        end
    end

    assign duty_a        = da_reg;
    assign duty_b        = db_reg;
    assign duty_c        = dc_reg;
    assign sector_code   = sec4_reg;
    assign overmodulated = over4_reg;

endmodule

// File: rtl/space_vector_pwm_q15_top.sv
// Each accepted request flows through the vector, divider and duty pipelines.
// Throughput: one request per cycle while m_tready is high; the depth is set
// by the 26-stage restoring divider rescaling both active times over the period.
// A bubble anywhere in the pipeline lets a new request in while a result waits.
// Reset clears all stage valid bits and loads inverse_bus_voltage with 1365.
`include "space_vector_pwm_q15_top_defines.svh"

module space_vector_pwm_q15_top
    import svpwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_wdata,  // inverse_bus_voltage
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // volt_alpha[23:0], volt_beta[47:24]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,    // duty_a[15:0], duty_b[31:16], duty_c[47:32]
    output logic [M_USER_W-1:0] m_tuser     // sector_code[2:0], overmodulated[3]
);

    logic [CFG_W-1:0]  inv_reg;

    logic              vec_valid;
    logic              vec_ready;
    vec_t              vec_data;
    logic              div_valid;
    logic              div_ready;
    quot_t             div_data;

    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    sector_t           sector_code;
    logic              overmodulated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= IBV_RESET;
        end
        else if (cfg_wen)
        begin
            inv_reg <= cfg_wdata;
        end
    end

    svpwm_vec u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .inv       (inv_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .alpha     ($signed(s_tdata[IN_W-1:0])),
        .beta      ($signed(s_tdata[2*IN_W-1:IN_W])),
        .out_valid (vec_valid),
        .out_ready (vec_ready),
        .out_data  (vec_data)
    );

    svpwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid),
        .in_ready  (vec_ready),
        .in_data   (vec_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    svpwm_duty u_duty (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (div_valid),
        .in_ready      (div_ready),
        .in_data       (div_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .duty_a        (duty_a),
        .duty_b        (duty_b),
        .duty_c        (duty_c),
        .sector_code   (sector_code),
        .overmodulated (overmodulated)
    );

    assign m_tdata = {duty_c, duty_b, duty_a};
    assign m_tuser = {overmodulated, sector_code};

    `SVPWM_ASSERT_NOW(a_zero_vector, m_tvalid && (sector_code == SEC_NONE_LO || sector_code == SEC_NONE_HI), duty_a == DUTY_HALF && duty_b == DUTY_HALF && duty_c == DUTY_HALF && !overmodulated, "zero vector sector must give half duty and no overmodulation")
    `SVPWM_ASSERT_NOW(a_duty_range, m_tvalid, duty_a <= DUTY_FULL && duty_b <= DUTY_FULL && duty_c <= DUTY_FULL, "phase duty above full period")
    `SVPWM_ASSERT_NOW(a_no_stall, !m_tvalid || m_tready, s_tready, "pipeline refused a request while the output could drain")
    `SVPWM_ASSERT_NEXT(a_cfg_load, cfg_wen, inv_reg == $past(cfg_wdata), "inverse bus voltage not loaded")

endmodule

// File: bench/svpwm_duty_checker.sv
`timescale 1ns / 100ps

module svpwm_duty_checker
    import svpwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // volt_alpha[23:0], volt_beta[47:24]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,    // duty_a[15:0], duty_b[31:16], duty_c[47:32]
    input  logic [M_USER_W-1:0] m_tuser,    // sector_code[2:0], overmodulated[3]
    output int                  errors,
    output int                  pending,
    output int                  results,
    output int                  scaled,
    output logic [7:0]          sectors_seen
);

    localparam longint K_PERIOD       = 32768;
    localparam longint K_SQRT3        = 56756;
    localparam longint K_HALF_SQRT3   = 28378;
    localparam longint K_THREE_HALVES = 49152;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        sector_t           sector;
        logic              over;
    } duty_rec_t;

    duty_rec_t        pending_duties[$];
    duty_rec_t        head;
    logic [CFG_W-1:0] inv_bus;

    function automatic longint mul15(longint a, longint b);
        return (a * b) >>> 15;
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(longint cmp);
        longint d;
        d = K_PERIOD - 2 * cmp;
        if (d < 0)
            d = 0;
        if (d > K_PERIOD)
            d = K_PERIOD;
        return d[DUTY_W-1:0];
    endfunction

    function automatic duty_rec_t svm_duties(logic [S_DATA_W-1:0] req, logic [CFG_W-1:0] ibv);
        longint    alpha, beta, inv, x, y, z, m, s, t_sum, ta, tb, tc, c1, c2, c3;
        logic [2:0] sec;
        duty_rec_t r;
        alpha = longint'($signed(req[23:0]));
        beta  = longint'($signed(req[47:24]));
        inv   = longint'(ibv);
        sec[0] = beta > 0;
        sec[1] = ((((K_SQRT3 * alpha) >>> 15) - beta) >>> 1) > 0;
        sec[2] = ((((-K_SQRT3 * alpha) >>> 15) - beta) >>> 1) > 0;
        r.sector = sector_t'(sec);
        r.over   = 1'b0;
        if (r.sector == SEC_NONE_LO || r.sector == SEC_NONE_HI)
        begin
            r.duty_a = DUTY_HALF;
            r.duty_b = DUTY_HALF;
            r.duty_c = DUTY_HALF;
            return r;
        end
        x = mul15(mul15(K_SQRT3, beta), inv);
        y = mul15(mul15(K_THREE_HALVES, alpha) + mul15(K_HALF_SQRT3, beta), inv);
        z = mul15(mul15(-K_THREE_HALVES, alpha) + mul15(K_HALF_SQRT3, beta), inv);
        case (r.sector)
            SEC_1:
            begin
                m = z;
                s = y;
            end
            SEC_2:
            begin
                m = y;
                s = -x;
            end
            SEC_3:
            begin
                m = -z;
                s = x;
            end
            SEC_4:
            begin
                m = -x;
                s = z;
            end
            SEC_5:
            begin
                m = x;
                s = -y;
            end
            default:
            begin
                m = -y;
                s = -z;
            end
        endcase
        // shrink both active times to fit the period, dividing by the unscaled sum
        if (m + s > K_PERIOD)
        begin
            t_sum  = m + s;
            m      = (m * K_PERIOD) / t_sum;
            s      = (s * K_PERIOD) / t_sum;
            r.over = 1'b1;
        end
        ta = (K_PERIOD - m - s) >>> 2;
        tb = ta + (m >>> 1);
        tc = tb + (s >>> 1);
        case (r.sector)
            SEC_1:
            begin
                c1 = tb;
                c2 = ta;
                c3 = tc;
            end
            SEC_2:
            begin
                c1 = ta;
                c2 = tc;
                c3 = tb;
            end
            SEC_3:
            begin
                c1 = ta;
                c2 = tb;
                c3 = tc;
            end
            SEC_4:
            begin
                c1 = tc;
                c2 = tb;
                c3 = ta;
            end
            SEC_5:
            begin
                c1 = tc;
                c2 = ta;
                c3 = tb;
            end
            default:
            begin
                c1 = tb;
                c2 = tc;
                c3 = ta;
            end
        endcase
        r.duty_a = clamp_duty(c1);
        r.duty_b = clamp_duty(c2);
        r.duty_c = clamp_duty(c3);
        return r;
    endfunction

    task report(input string what, input longint got, input longint want);
        $display("%0t: MISMATCH %s: got %0d, expected %0d (result %0d)",
                 $time, what, got, want, results);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_bus = IBV_RESET;
            pending_duties.delete();
            errors       = 0;
            pending      = 0;
            results      = 0;
            scaled       = 0;
            sectors_seen = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_duties.push_back(svm_duties(s_tdata, inv_bus));
            if (cfg_wen)
                inv_bus = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                results++;
                if (pending_duties.size() == 0)
                    report("result with no request waiting", longint'(m_tdata[15:0]), 0);
                else
                begin
                    head = pending_duties.pop_front();
                    if (m_tdata[15:0] !== head.duty_a)
                        report("duty_a", longint'(m_tdata[15:0]), longint'(head.duty_a));
                    if (m_tdata[31:16] !== head.duty_b)
                        report("duty_b", longint'(m_tdata[31:16]), longint'(head.duty_b));
                    if (m_tdata[47:32] !== head.duty_c)
                        report("duty_c", longint'(m_tdata[47:32]), longint'(head.duty_c));
                    if (m_tuser[2:0] !== head.sector)
                        report("sector_code", longint'(m_tuser[2:0]), longint'(head.sector));
                    if (m_tuser[3] !== head.over)
                        report("overmodulated", longint'(m_tuser[3]), longint'(head.over));
                    scaled += int'(head.over);
                    sectors_seen[head.sector] = 1'b1;
                end
            end
            pending = pending_duties.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import svpwm_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_wen;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    int         errors, pending, results, scaled;
    logic [7:0] sectors_seen;
    logic       steady;
    int         requests, settings;

    space_vector_pwm_q15_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    svpwm_duty_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .pending      (pending),
        .results      (results),
        .scaled       (scaled),
        .sectors_seen (sectors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // random signed value in [-2^(bits-1), 2^(bits-1))
    function automatic logic signed [23:0] span(int bits);
        int v;
        v = $urandom;
        return 24'(v >>> (32 - bits));
    endfunction

    function automatic logic [S_DATA_W-1:0] rand_request();
        logic signed [23:0] a, b;
        longint             t;
        int                 kind;
        kind = $urandom_range(9, 0);
        case (kind)
            0, 1:
            begin
                a = 24'($urandom);
                b = 24'($urandom);
            end
            2, 3:
            begin
                a = span(16);
                b = span(16);
            end
            4, 5:
            begin
                a = span(20);
                b = span(20);
            end
            6:
            begin
                // land near a sector boundary
                a = span(18);
                t = (longint'(56756) * longint'(a)) >>> 15;
                b = ($urandom_range(1, 0) ? 24'(t) : 24'(-t)) + span(3);
            end
            7:
            begin
                if ($urandom_range(1, 0))
                begin
                    a = span(4);
                    b = span(20);
                end
                else
                begin
                    a = span(20);
                    b = span(4);
                end
            end
            default:
            begin
                a = span($urandom_range(24, 1));
                b = span($urandom_range(24, 1));
            end
        endcase
        return {b, a};
    endfunction

    task send_request(input logic signed [23:0] alpha, input logic signed [23:0] beta);
        int gap;
        gap = steady ? 0 : $urandom_range(13, 0);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {beta, alpha};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        requests++;
    endtask

    task set_bus(input logic [CFG_W-1:0] value);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen = 1'b0;
        settings++;
    endtask

    function automatic logic [CFG_W-1:0] bus_plan(int phase);
        case (phase)
            0:       return 15'd32767;
            1:       return 15'd0;
            2:       return CFG_W'($urandom_range(32767, 1));
            3:       return 15'd1;
            4:       return IBV_RESET;
            5:       return CFG_W'($urandom_range(32767, 0));
            default: return 15'd23170;
        endcase
    endfunction

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = steady ? 0 : $urandom_range(13, 0);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [S_DATA_W-1:0] req;
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        steady    = 1'b0;
        requests  = 0;
        settings  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(24'sd0, 24'sd0);
        send_request(24'sh7FFFFF, 24'sh7FFFFF);
        send_request(24'sh800000, 24'sh800000);
        send_request(24'sh7FFFFF, 24'sh800000);
        send_request(24'sh800000, 24'sh7FFFFF);
        send_request(24'sh7FFFFF, 24'sd0);
        send_request(24'sh800000, 24'sd0);
        send_request(24'sd0, 24'sh7FFFFF);
        send_request(24'sd0, 24'sh800000);
        send_request(24'sd1, 24'sd0);
        send_request(-24'sd1, 24'sd0);
        send_request(24'sd0, 24'sd1);
        send_request(24'sd0, -24'sd1);
        send_request(-24'sd1, -24'sd1);
        send_request(24'sd1, 24'sd1);
        send_request(24'sd28378, 24'sd16384);
        send_request(24'sd0, 24'sd32767);
        send_request(-24'sd28378, 24'sd16384);
        send_request(-24'sd28378, -24'sd16384);
        send_request(24'sd0, -24'sd32767);
        send_request(24'sd28378, -24'sd16384);
        send_request(24'sd1000000, 24'sd300000);
        send_request(-24'sd1000000, -24'sd300000);

        for (int phase = 0; phase < 7; phase++)
        begin
            set_bus(bus_plan(phase));
            steady = (phase % 3 == 1);
            for (int n = 0; n < 200; n++)
            begin
                req = rand_request();
                send_request(req[23:0], req[47:24]);
            end
        end

        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Sent %0d duty requests over %0d bus-voltage settings after the reset value;",
                 requests, settings);
        $display("checked %0d results, %0d rescaled to fit the period, sector codes seen %b.",
                 results, scaled, sectors_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/svpwm_pkg.sv
rtl/svpwm_vec.sv
rtl/svpwm_div.sv
rtl/svpwm_duty.sv
rtl/space_vector_pwm_q15_top.sv
bench/svpwm_duty_checker.sv
bench/tb.sv
